FILE: hdl/pvm_pkg.sv
package pvm_pkg;

  localparam int VOICES_DEF = 8;
  localparam int SAMPLE_ADDR_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MUSIC_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MUSIC_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MUSIC_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MUSIC_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MUSIC_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LENGTH  = 3'd6;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_MIX   = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  localparam logic [19:0] STEP_RESET  = 20'd30106;
  localparam logic [8:0]  MGAIN_RESET = 9'd112;
  localparam logic [9:0]  EDGE_RESET  = 10'd88;
  localparam logic [8:0]  UNITY_GAIN  = 9'd256;
  localparam logic [8:0]  DB_FACTOR   = 9'd228;
  localparam logic [7:0]  PCM_OFFSET  = 8'd128;
  localparam int DIV_BITS = 16;

endpackage

FILE: hdl/pvm_ram.sv
module pvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/pcm_voice_mixer.sv
// channel | direction | handshake             | payload
// in      | sink      | in_valid / in_ready   | kind address data sound_length attenuation_db
// out     | source    | out_valid / out_ready | mixed_sample started voice_index active_mask
// cfg     | sink      | cfg_valid / cfg_ready | cfg_index cfg_data
//
// A start item runs one multiply per dB of attenuation_db on the shared multiplier.
// A mix item handles music and then each active effect voice; each effect voice
// also runs the 16-step divider, and a voice already past its end skips both the
// multiplies and the divider.
// Synchronous reset clears voice activity, music position and registers; sample memory
// and voice parameters are left as they are. While the output word is stalled the
// sequencer waits in its last state; the input is taken again once it is idle.
module pcm_voice_mixer #(
  parameter int VOICES = pvm_pkg::VOICES_DEF,
  parameter int SAMPLE_ADDR_BITS = pvm_pkg::SAMPLE_ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic [15:0]                    address,
  input  logic [7:0]                     data,
  input  logic [16:0]                    sound_length,
  input  logic [5:0]                     attenuation_db,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             mixed_sample,
  output logic                           started,
  output logic [2:0]                     voice_index,
  output logic [7:0]                     active_mask,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pvm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pvm_pkg::*;

  localparam int VB = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCW = $clog2(VOICES + 1);
  localparam int SAB = SAMPLE_ADDR_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEL  = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_INT  = 4'd4;
  localparam logic [3:0] S_M1   = 4'd5;
  localparam logic [3:0] S_M2   = 4'd6;
  localparam logic [3:0] S_DIV0 = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;
  localparam logic [3:0] S_GAIN = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state;

  // configuration
  logic        music_enable;
  logic [15:0] music_base;
  logic [16:0] music_length;
  logic [19:0] mus_step;
  logic [8:0]  music_gain;
  logic [19:0] voice_step;
  logic [9:0]  edge_length;
  logic [9:0]  edge_e;

  logic [31:0] music_pos;
  logic [VOICES-1:0] active;
  logic [15:0] vbase [VOICES];
  logic [16:0] vlen  [VOICES];
  logic [31:0] vpos  [VOICES];
  logic [8:0]  vgain [VOICES];

  // current voice
  logic [VCW-1:0] vc;
  logic           in_music;
  logic [15:0]    cbase;
  logic [16:0]    clen;
  logic [31:0]    cpos;
  logic [19:0]    cstep;
  logic [8:0]     cgain;
  logic [9:0]     cenv;
  logic signed [8:0] sa;
  logic signed [20:0] sum;

  // shared multiplier
  logic signed [16:0] op_a;
  logic signed [17:0] op_b;
  logic signed [34:0] mul_p;
  assign mul_p = op_a * op_b;

  // divider
  logic [9:0]  rem;
  logic [15:0] qreg;
  logic        dneg;
  logic [4:0]  dcnt;
  logic [10:0] r2;
  logic        qbit;

  logic [5:0]    gcnt;
  logic [VB-1:0] slot;
  logic signed [15:0] p_mixed;
  logic          p_started;
  logic [2:0]    p_slot;

  logic          free_found;
  logic [VB-1:0] free_slot;
  logic [31:0]   slot32;

  logic          accept;
  logic          ram_we;
  logic [SAB-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic [24:0]   addr_sum;
  logic [15:0]   cidx;
  logic          have_next;

  // selection helpers
  logic [VB-1:0] vsel;
  logic [15:0]   sidx;
  logic [16:0]   sidx1;
  logic [9:0]    senv;
  logic [16:0]   srel;

  logic signed [34:0] interp_sh;
  logic signed [8:0]  v9;
  logic signed [8:0]  b9;
  logic signed [15:0] s16;
  logic [25:0]        mag;
  logic signed [16:0] contrib;
  logic [31:0]        pos_next;
  logic [7:0]         mask8;

  function automatic logic signed [15:0] sat16(input logic signed [34:0] x);
    if (x > 35'sd32767) begin
      return 16'sh7fff;
    end else if (x < -35'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign edge_e = (edge_length == 10'd0) ? 10'd1 : edge_length;

  always_comb begin
    free_found = 1'b0;
    free_slot = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!active[v]) begin
        free_found = 1'b1;
        free_slot = VB'(v);
      end
    end
  end

  assign slot32 = 32'(free_slot);

  always_comb begin
    mask8 = '0;
    for (int v = 0; v < VOICES && v < 8; v++) begin
      mask8[v] = active[v];
    end
  end

  // memory address: write at accept, first tap in S_RDA, second tap in S_RDB
  assign cidx = cpos[31:16];
  assign have_next = ({1'b0, cidx} + 17'd1) < clen;
  assign addr_sum = 25'(cbase) + 25'(cidx) + ((state == S_RDB) ? 25'd1 : 25'd0);
  assign ram_we = accept && (kind == KIND_WRITE);
  assign ram_addr = ram_we ? SAB'(25'(address)) : addr_sum[SAB-1:0];

  pvm_ram #(
    .WIDTH(8),
    .DEPTH(1 << SAB)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(data),
    .rdata(ram_rdata)
  );

  // envelope for the voice under the counter
  assign vsel = vc[VB-1:0];
  assign sidx = vpos[vsel][31:16];
  assign sidx1 = {1'b0, sidx} + 17'd1;
  assign srel = vlen[vsel] - {1'b0, sidx};
  always_comb begin
    senv = edge_e;
    if (sidx1 < {7'd0, senv}) begin
      senv = sidx1[9:0];
    end
    if (vlen[vsel] >= {1'b0, sidx} && srel < {7'd0, senv}) begin
      senv = srel[9:0];
    end
  end

  assign b9 = have_next ? $signed({1'b0, ram_rdata} - {1'b0, PCM_OFFSET}) : sa;
  assign interp_sh = mul_p >>> 16;
  assign v9 = sa + interp_sh[8:0];
  assign s16 = sat16(mul_p);
  assign mag = mul_p[34] ? 26'(-mul_p) : mul_p[25:0];
  assign r2 = {rem, qreg[15]};
  assign qbit = r2 >= {1'b0, edge_e};
  assign contrib = dneg ? -$signed({1'b0, qreg}) : $signed({1'b0, qreg});
  assign pos_next = cpos + 32'(cstep);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      music_pos <= '0;
      music_enable <= 1'b0;
      music_base <= '0;
      music_length <= '0;
      mus_step <= STEP_RESET;
      music_gain <= MGAIN_RESET;
      voice_step <= STEP_RESET;
      edge_length <= EDGE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MUSIC_ENABLE: begin
            music_enable <= cfg_data[0];
            music_pos <= '0;
          end
          REG_MUSIC_BASE:   music_base <= cfg_data[15:0];
          REG_MUSIC_LENGTH: music_length <= cfg_data[16:0];
          REG_MUSIC_STEP:   mus_step <= cfg_data[19:0];
          REG_MUSIC_GAIN:   music_gain <= cfg_data[8:0];
          REG_VOICE_STEP:   voice_step <= cfg_data[19:0];
          REG_EDGE_LENGTH:  edge_length <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            p_mixed <= '0;
            p_started <= 1'b0;
            p_slot <= '0;
            sum <= '0;
            vc <= '0;
            in_music <= music_enable;
            slot <= free_slot;
            gcnt <= attenuation_db;
            op_a <= 17'(UNITY_GAIN);
            op_b <= 18'(DB_FACTOR);
            case (kind)
              KIND_START: state <= free_found ? S_GAIN : S_DONE;
              KIND_MIX:   state <= S_SEL;
              KIND_STOP: begin
                active <= '0;
                music_enable <= 1'b0;
                music_pos <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
            if (kind == KIND_START && free_found) begin
              // the word is gone after this edge, so its fields go in now
              vbase[free_slot] <= address;
              vlen[free_slot] <= sound_length;
              vpos[free_slot] <= '0;
              p_slot <= slot32[2:0];
            end
          end
        end
        S_GAIN: begin
          if (gcnt == 6'd0) begin
            vgain[slot] <= op_a[8:0];
            active[slot] <= 1'b1;
            p_started <= 1'b1;
            state <= S_DONE;
          end else begin
            op_a <= 17'(mul_p[16:8]);
            gcnt <= gcnt - 6'd1;
          end
        end
        S_SEL: begin
          if (in_music) begin
            cbase <= music_base;
            clen <= music_length;
            cpos <= ({1'b0, music_pos[31:16]} >= music_length) ? '0 : music_pos;
            cstep <= mus_step;
            cgain <= music_gain;
            state <= S_RDA;
          end else if (vc == VCW'(VOICES)) begin
            p_mixed <= sat16(35'(sum));
            state <= S_DONE;
          end else if (!active[vsel]) begin
            vc <= vc + 1'b1;
          end else begin
            cbase <= vbase[vsel];
            clen <= vlen[vsel];
            cpos <= vpos[vsel];
            cstep <= voice_step;
            cgain <= vgain[vsel];
            cenv <= senv;
            state <= S_RDA;
          end
        end
        S_RDA: begin
          if ({1'b0, cidx} >= clen) begin
            // past the end: silent, position back to zero
            if (in_music) begin
              music_pos <= '0;
              in_music <= 1'b0;
            end else begin
              vpos[vsel] <= '0;
              active[vsel] <= (clen != 17'd0);
              vc <= vc + 1'b1;
            end
            state <= S_SEL;
          end else begin
            state <= S_RDB;
          end
        end
        S_RDB: begin
          sa <= $signed({1'b0, ram_rdata} - {1'b0, PCM_OFFSET});
          state <= S_INT;
        end
        S_INT: begin
          op_a <= 17'(b9 - sa);
          op_b <= {2'b00, cpos[15:0]};
          state <= S_M1;
        end
        S_M1: begin
          op_a <= 17'(v9);
          op_b <= {9'd0, cgain};
          state <= S_M2;
        end
        S_M2: begin
          cpos <= pos_next;
          if (in_music) begin
            sum <= sum + 21'(s16);
            music_pos <= pos_next;
            in_music <= 1'b0;
            state <= S_SEL;
          end else begin
            op_a <= 17'(s16);
            op_b <= {8'd0, cenv};
            state <= S_DIV0;
          end
        end
        S_DIV0: begin
          dneg <= mul_p[34];
          rem <= mag[25:16];
          qreg <= mag[15:0];
          dcnt <= 5'(DIV_BITS);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= qbit ? 10'(r2 - {1'b0, edge_e}) : r2[9:0];
          qreg <= {qreg[14:0], qbit};
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd1) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sum <= sum + 21'(contrib);
          vpos[vsel] <= cpos;
          if ({1'b0, cpos[31:16]} >= clen) begin
            active[vsel] <= 1'b0;
          end
          vc <= vc + 1'b1;
          state <= S_SEL;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            mixed_sample <= p_mixed;
            started <= p_started;
            voice_index <= p_slot;
            active_mask <= mask8;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/pvm_checker.sv
module pvm_checker #(
  parameter int VOICES = pvm_pkg::VOICES_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     kind,
  input logic [15:0]                    address,
  input logic [7:0]                     data,
  input logic [16:0]                    sound_length,
  input logic [5:0]                     attenuation_db,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [15:0]             mixed_sample,
  input logic                           started,
  input logic [2:0]                     voice_index,
  input logic [7:0]                     active_mask,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [pvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [pvm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a held word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mixed_sample) && $stable(active_mask))
    else $error("output word changed while stalled");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !started |-> voice_index == 3'd0)
    else $error("slot reported without a start");

  a_mix_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && mixed_sample != 16'sd0 |-> !started)
    else $error("sample and start in one word");

  a_slot_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && started && VOICES <= 8 |-> active_mask[voice_index])
    else $error("started slot not active");

endmodule

bind pcm_voice_mixer pvm_checker #(.VOICES(VOICES)) u_pvm_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pvm_pkg::*;

  // every voice reads inside this window, which wraps past the top address
  localparam bit [15:0] WIN_BASE = 16'hFFF0;
  localparam int WIN_SIZE = 64;

  typedef struct {
    logic signed [15:0] mixed;
    bit                 started;
    bit [2:0]           slot;
    bit [7:0]           mask;
  } mix_word_t;

  class mixer_scoreboard;
    bit [7:0]  mem [0:65535];
    bit [31:0] music_pos;
    bit        vact [8];
    bit [31:0] vbase [8];
    bit [31:0] vlen [8];
    bit [31:0] vpos [8];
    bit [31:0] vgain [8];
    bit [31:0] m_en, m_base, m_len, m_step, m_gain, v_step, edge_len;
    mix_word_t expected_words [$];
    int        errors;
    int        words_seen;

    function void reset_state();
      music_pos = 0;
      foreach (vact[v]) vact[v] = 0;
      m_en = 0; m_base = 0; m_len = 0; m_step = STEP_RESET;
      m_gain = MGAIN_RESET; v_step = STEP_RESET; edge_len = EDGE_RESET;
    endfunction

    function void set_reg(bit [2:0] idx, bit [19:0] val);
      case (idx)
        REG_MUSIC_ENABLE: begin
          m_en = val[0];
          music_pos = 0;
        end
        REG_MUSIC_BASE:   m_base = val[15:0];
        REG_MUSIC_LENGTH: m_len = val[16:0];
        REG_MUSIC_STEP:   m_step = val;
        REG_MUSIC_GAIN:   m_gain = val[8:0];
        REG_VOICE_STEP:   v_step = val;
        REG_EDGE_LENGTH:  edge_len = val[9:0];
        default: ;
      endcase
    endfunction

    function int sat16(int x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
    endfunction

    function int pcm_at(bit [31:0] base, bit [31:0] idx);
      bit [31:0] a;
      a = base + idx;
      return int'(mem[a[15:0]]) - 128;
    endfunction

    // one interpolated, gained and clipped voice sample; advances pos
    function int voice_out(bit [31:0] base, bit [31:0] len, inout bit [31:0] pos,
                           bit [31:0] step, bit [31:0] gain);
      bit [31:0] idx;
      int frac, a, b, x;
      idx = pos >> 16;
      frac = int'(pos[15:0]);
      if (idx >= len) begin
        pos = 0;
        return 0;
      end
      a = pcm_at(base, idx);
      b = (idx + 1 < len) ? pcm_at(base, idx + 1) : a;
      x = a + (((b - a) * frac) >>> 16);
      x = x * 256;
      x = (x * int'(gain)) >>> 8;
      pos = pos + step;
      return sat16(x);
    endfunction

    function int mix_sample();
      int sum, s;
      bit [31:0] edge_eff, idx, env, rel;
      sum = 0;
      edge_eff = (edge_len == 0) ? 1 : edge_len;
      if (m_en) begin
        if ((music_pos >> 16) >= m_len) music_pos = 0;
        sum += voice_out(m_base, m_len, music_pos, m_step, m_gain);
      end
      for (int v = 0; v < 8; v++) begin
        if (vact[v]) begin
          idx = vpos[v] >> 16;
          env = edge_eff;
          if (idx + 1 < env) env = idx + 1;
          rel = vlen[v] - idx;
          if (rel < env) env = rel;
          s = voice_out(vbase[v], vlen[v], vpos[v], v_step, vgain[v]);
          sum += (s * int'(env)) / int'(edge_eff);
          if ((vpos[v] >> 16) >= vlen[v]) vact[v] = 0;
        end
      end
      return sat16(sum);
    endfunction

    function void note_item(bit [1:0] k, bit [15:0] addr, bit [7:0] d,
                            bit [16:0] slen, bit [5:0] att);
      mix_word_t w;
      bit [31:0] g;
      int mixed;
      w.mixed = 0; w.started = 0; w.slot = 0; w.mask = 0;
      case (k)
        KIND_WRITE: mem[addr] = d;
        KIND_START: begin
          for (int v = 0; v < 8; v++) begin
            if (!vact[v] && !w.started) begin
              g = 256;
              repeat (att) g = g * 228 / 256;
              vbase[v] = addr; vlen[v] = slen; vpos[v] = 0; vgain[v] = g;
              vact[v] = 1;
              w.started = 1;
              w.slot = v;
            end
          end
        end
        KIND_MIX: begin
          mixed = mix_sample();
          w.mixed = mixed[15:0];
        end
        default: begin
          foreach (vact[v]) vact[v] = 0;
          m_en = 0;
          music_pos = 0;
        end
      endcase
      foreach (vact[v]) w.mask[v] = vact[v];
      expected_words.push_back(w);
    endfunction

    function void check_word(logic signed [15:0] mixed, logic st, logic [2:0] slot,
                             logic [7:0] mask);
      mix_word_t e;
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word mixed=%0d started=%b slot=%0d mask=%h",
                 $time, mixed, st, slot, mask);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (mixed !== e.mixed) begin
        $display("%0t: mixed_sample expected %0d actual %0d", $time, e.mixed, mixed);
        errors++;
      end
      if (st !== e.started) begin
        $display("%0t: started expected %b actual %b", $time, e.started, st);
        errors++;
      end
      if (slot !== e.slot) begin
        $display("%0t: voice_index expected %0d actual %0d", $time, e.slot, slot);
        errors++;
      end
      if (mask !== e.mask) begin
        $display("%0t: active_mask expected %h actual %h", $time, e.mask, mask);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] kind = 0;
  logic [15:0] address = 0;
  logic [7:0] data = 0;
  logic [16:0] sound_length = 0;
  logic [5:0] attenuation_db = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] mixed_sample;
  logic started;
  logic [2:0] voice_index;
  logic [7:0] active_mask;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  bit in_idle = 0;
  bit out_idle = 0;
  bit hold_out = 0;
  bit press_go = 0;
  int items_sent = 0;

  mixer_scoreboard sb = new();

  pcm_voice_mixer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .address(address), .data(data),
    .sound_length(sound_length), .attenuation_db(attenuation_db),
    .out_valid(out_valid), .out_ready(out_ready),
    .mixed_sample(mixed_sample), .started(started),
    .voice_index(voice_index), .active_mask(active_mask),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_word(mixed_sample, started, voice_index, active_mask);
      if (hold_out) out_ready <= 0;
      else if (out_idle) out_ready <= ($urandom_range(99) >= 32);
      else out_ready <= 1;
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    wait (press_go);
    @(posedge clk);
    hold_out = 1;
    repeat (600) @(posedge clk);
    hold_out = 0;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_word(bit [1:0] k, bit [15:0] a, bit [7:0] d, bit [16:0] l,
                           bit [5:0] att);
    if (in_idle && $urandom_range(99) < 32) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k; address <= a; data <= d; sound_length <= l; attenuation_db <= att;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, a, d, l, att);
    items_sent++;
  endtask

  task automatic write_reg(bit [2:0] idx, bit [19:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic load_regs(bit en, bit [15:0] base, bit [16:0] len, bit [19:0] ms,
                           bit [8:0] mg, bit [19:0] vs, bit [9:0] edge_v);
    write_reg(REG_MUSIC_BASE, base);
    write_reg(REG_MUSIC_LENGTH, len);
    write_reg(REG_MUSIC_STEP, ms);
    write_reg(REG_MUSIC_GAIN, mg);
    write_reg(REG_VOICE_STEP, vs);
    write_reg(REG_EDGE_LENGTH, edge_v);
    write_reg(REG_MUSIC_ENABLE, en);
  endtask

  function automatic bit [19:0] pick_step();
    case ($urandom_range(9))
      0: return 0;
      1: return 20'hFFFFF;
      2, 3: return $urandom_range(20'hFFFFF);
      default: return $urandom_range(20'h30000);
    endcase
  endfunction

  task automatic rand_regs();
    bit [16:0] len;
    bit [9:0] edge_v;
    int o;
    o = $urandom_range(WIN_SIZE - 1);
    case ($urandom_range(5))
      0: len = 0;
      1: len = 17'(WIN_SIZE - o);
      default: len = 17'($urandom_range(WIN_SIZE - o));
    endcase
    edge_v = ($urandom_range(3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 120);
    load_regs($urandom_range(1), 16'(WIN_BASE + o), len, pick_step(),
              9'($urandom_range(256)), pick_step(), edge_v);
  endtask

  task automatic rand_word();
    bit [16:0] l;
    int r, o;
    r = $urandom_range(99);
    o = $urandom_range(WIN_SIZE - 1);
    case ($urandom_range(9))
      0: l = 0;
      1: l = 17'(WIN_SIZE - o);
      default: l = 17'($urandom_range(WIN_SIZE - o));
    endcase
    if (r < 60) send_word(KIND_MIX, $urandom, $urandom, $urandom, $urandom);
    else if (r < 82) send_word(KIND_START, 16'(WIN_BASE + o), $urandom, l,
                               $urandom_range(63));
    else if (r < 97) send_word(KIND_WRITE, $urandom, $urandom, $urandom, $urandom);
    else send_word(KIND_STOP, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    sb.reset_state();
    @(posedge clk);

    // fill the read window so every read hits a written byte
    for (int a = 0; a < WIN_SIZE; a++)
      send_word(KIND_WRITE, 16'(WIN_BASE + a), $urandom, 0, 0);
    drain();

    // directed: short edge, full gain, then slot exhaustion
    load_regs(1, 16'hFFF8, 17'd40, STEP_RESET, 9'd256, STEP_RESET, 10'd4);
    send_word(KIND_MIX, 0, 0, 0, 0);
    send_word(KIND_START, 16'hFFFF, 0, 17'd49, 6'd0);
    send_word(KIND_START, 16'h0000, 0, 17'd0, 6'd63);
    send_word(KIND_MIX, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++)
      send_word(KIND_START, 16'(WIN_BASE + 4 * i), 0, 17'(20 + i), 6'(i * 9));
    send_word(KIND_WRITE, 16'hFFFF, 8'hFF, 0, 0);
    send_word(KIND_WRITE, 16'h0000, 8'h00, 0, 0);
    for (int i = 0; i < 6; i++) send_word(KIND_MIX, 0, 0, 0, 0);
    send_word(KIND_STOP, 0, 0, 0, 0);
    send_word(KIND_MIX, 0, 0, 0, 0);
    drain();

    // zero edge, full-range lengths held in place by zero steps
    load_regs(1, 16'hFFF0, 17'h10000, 20'd0, 9'd256, 20'd0, 10'd0);
    send_word(KIND_START, 16'h0000, 0, 17'h10000, 6'd1);
    send_word(KIND_START, 16'h0010, 0, 17'd5, 6'd0);
    for (int i = 0; i < 4; i++) send_word(KIND_MIX, 0, 0, 0, 0);
    send_word(KIND_STOP, 0, 0, 0, 0);
    drain();

    // top steps on short lengths: music wraps, effect ends early
    load_regs(1, 16'hFFF4, 17'd60, 20'hFFFFF, 9'd256, 20'hFFFFF, 10'd0);
    send_word(KIND_START, 16'h0000, 0, 17'd48, 6'd1);
    for (int i = 0; i < 8; i++) send_word(KIND_MIX, 0, 0, 0, 0);
    drain();
    load_regs(1, 16'h0010, 17'd1, 20'd0, 9'd0, 20'd0, 10'd1023);
    send_word(KIND_START, 16'h0020, 0, 17'd1, 6'd10);
    for (int i = 0; i < 4; i++) send_word(KIND_MIX, 0, 0, 0, 0);
    send_word(KIND_STOP, 0, 0, 0, 0);
    drain();

    // random phases, idling on both sides after a first clean stretch
    for (int ph = 0; ph < 4; ph++) begin
      rand_regs();
      if (ph == 1) begin
        in_idle = 0;
        press_go = 1;
      end else begin
        in_idle = (ph != 0);
        out_idle = (ph != 0);
      end
      for (int i = 0; i < 72; i++) rand_word();
      drain();
    end

    $display("Covered %0d items: window fill, directed extremes, slot exhaustion,",
             items_sent);
    $display("%0d result words checked over random register settings and stalls",
             sb.words_seen);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
